// ===== src/spmr_pkg.sv =====
// ----------------------------------------------------------------------------
// spmr_pkg: shared types and constants of the shuffled Park-Miller generator
// Widths of the generator word, the shuffle table geometry and the table
// write port shared by the core and its memory.
// ----------------------------------------------------------------------------
`default_nettype none

package spmr_pkg;

	// Generator word: values lie in 1 .. 2^31-1.
	localparam int VAL_W = 31;
	localparam int MUL_W = 15;
	localparam int PROD_W = VAL_W + MUL_W;

	localparam logic [MUL_W-1:0] PM_MUL = MUL_W'(16807);
	localparam logic [VAL_W-1:0] PM_MOD = VAL_W'(2147483647);

	// The shuffle table depth is a power of two, so the slot is the low bits
	// of the selector.
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);

	// A reseed runs eight steps beyond the table depth.
	localparam int WARMUP_STEPS = TABLE_DEPTH + 8;
	localparam int CNT_W = $clog2(WARMUP_STEPS);

	localparam int DATA_W = 32;
	localparam int SPAN_W = DATA_W + 1;

	localparam logic [VAL_W-1:0] RESET_SEED = VAL_W'(1);

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		val_t data;
	} tbl_wr_t;

endpackage

`default_nettype wire

// ===== src/spmr_table.sv =====
// ----------------------------------------------------------------------------
// spmr_table: shuffle table memory
// Synchronous RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spmr_table (
	input  wire logic             clk,
	input  wire spmr_pkg::tbl_wr_t wr,
	input  wire logic             rd_en,
	input  wire spmr_pkg::idx_t   rd_addr,
	output spmr_pkg::val_t        rd_data
);

	spmr_pkg::val_t mem [spmr_pkg::TABLE_DEPTH];
	spmr_pkg::val_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== src/spmr_step.sv =====
// ----------------------------------------------------------------------------
// spmr_step: one minimal standard generator step
// Multiplies by 16807 in the first stage and folds the product modulo
// 2^31-1 in the second; done rises together with the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module spmr_step (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire spmr_pkg::val_t x,
	output logic                done,
	output spmr_pkg::val_t      result
);

	logic [spmr_pkg::PROD_W-1:0] product_s1;
	logic                        v_s1;
	logic                        v_s2;
	spmr_pkg::val_t              fold_s2;
	logic [spmr_pkg::VAL_W:0]    sum;
	logic [spmr_pkg::VAL_W:0]    wrap;
	spmr_pkg::val_t              fold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	// Since 2^31 is congruent to 1, the high part of the product adds to the low part.
	// A zero sum only arises from a zero product and maps to the modulus, as does
	// a seed equal to the modulus.
	always_comb begin
		sum = {{(spmr_pkg::VAL_W + 1 - spmr_pkg::MUL_W){1'b0}},
			product_s1[spmr_pkg::PROD_W-1 -: spmr_pkg::MUL_W]}
			+ {1'b0, product_s1[spmr_pkg::VAL_W-1:0]};
		wrap = sum - {1'b0, spmr_pkg::PM_MOD};
		if (sum == '0) begin
			fold = spmr_pkg::PM_MOD;
		end else if (sum > {1'b0, spmr_pkg::PM_MOD}) begin
			fold = wrap[spmr_pkg::VAL_W-1:0];
		end else begin
			fold = sum[spmr_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		product_s1 <= spmr_pkg::PROD_W'(x) * spmr_pkg::PROD_W'(spmr_pkg::PM_MUL);
		fold_s2 <= fold;
	end

	assign done = v_s2;
	assign result = fold_s2;

endmodule

`default_nettype wire

// ===== src/spmr_divider.sv =====
// ----------------------------------------------------------------------------
// spmr_divider: bit-serial remainder unit
// Restoring division of a 31-bit entry by a span of up to 2^32, one bit a
// cycle; done pulses with the remainder once the last dividend bit is in.
// ----------------------------------------------------------------------------
`default_nettype none

module spmr_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire spmr_pkg::val_t               dividend,
	input  wire logic [spmr_pkg::SPAN_W-1:0]  divisor,
	output logic                              done,
	output spmr_pkg::val_t                    remainder
);

	localparam int BIT_CNT_W = $clog2(spmr_pkg::VAL_W);
	localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(spmr_pkg::VAL_W - 1);

	logic                        run_q;
	logic                        done_q;
	logic [BIT_CNT_W-1:0]        cnt_q;
	spmr_pkg::val_t              dvd_q;
	spmr_pkg::val_t              rem_q;
	logic [spmr_pkg::SPAN_W-1:0] dsr_q;
	logic [spmr_pkg::VAL_W:0]    trial;
	logic [spmr_pkg::VAL_W:0]    diff;
	spmr_pkg::val_t              rem_d;

	// The partial remainder never exceeds the dividend prefix, so it stays
	// below 2^31 and the trial value has a clear top bit.
	always_comb begin
		trial = {rem_q, dvd_q[spmr_pkg::VAL_W-1]};
		diff = trial - dsr_q[spmr_pkg::VAL_W:0];
		if ({1'b0, trial} >= dsr_q) begin
			rem_d = diff[spmr_pkg::VAL_W-1:0];
		end else begin
			rem_d = trial[spmr_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[spmr_pkg::VAL_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== src/shuffled_park_miller_rng_core.sv =====
// ----------------------------------------------------------------------------
// shuffled_park_miller_rng_core: shuffled minimal standard random generator
// Park-Miller generator behind a shuffle table, with range reduction.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at a rising edge where start is high and busy is low.
//   req_type 1 reseeds: seed (zero acts as one) runs 40 generator steps and
//   the last 32 fill the shuffle table; no result word follows. A reseed
//   keeps busy high while its steps run one after another in the shared step unit.
//   req_type 0 draws: the generator advances, the new value replaces the
//   table slot picked by the last entry read, and the old entry, reduced modulo
//   range_high - range_low + 1 and offset by range_low, is the result.
//   Reversed bounds return range_low with clamped set once the generator
//   step is done. Otherwise the serial remainder unit sets the rate: valid
//   pulses in the same cycle in which busy first lets the next word in.
//   valid marks a result for exactly one cycle; the receiver cannot stall.
//   After reset the block runs the reseed sequence with seed 1, which fills
//   the table; busy stays high until that sequence ends.
//   Only one word is in flight, so table reads and writes never overlap.
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_park_miller_rng_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic signed [31:0] range_low,
	input  wire logic signed [31:0] range_high,
	input  wire logic [30:0] seed,
	output logic             valid,
	output logic signed [31:0] random_value,
	output logic             clamped
);

	typedef enum logic [2:0] {
		ST_SEED_GO,
		ST_SEED_WAIT,
		ST_IDLE,
		ST_DRAW_WAIT,
		ST_DIV
	} state_t;

	state_t                                state_q;
	spmr_pkg::val_t                        x_q;
	logic [spmr_pkg::CNT_W-1:0]            cnt_q;
	logic                                  valid_q;
	logic [spmr_pkg::DATA_W-1:0]           random_value_q;
	logic                                  clamped_q;

	spmr_pkg::val_t                        gen_q;
	spmr_pkg::val_t                        sel_q;
	logic [spmr_pkg::DATA_W-1:0]           lo_q;
	logic [spmr_pkg::SPAN_W-1:0]           span_q;
	logic                                  rev_q;
	spmr_pkg::idx_t                        slot_q;

	logic                                  accept;
	logic                                  draw_go;
	logic                                  step_go;
	spmr_pkg::val_t                        step_x;
	logic                                  step_done;
	spmr_pkg::val_t                        step_val;
	spmr_pkg::tbl_wr_t                     tbl_wr;
	spmr_pkg::val_t                        tbl_rd_data;
	logic                                  div_go;
	logic                                  div_done;
	spmr_pkg::val_t                        div_rem;
	logic [spmr_pkg::SPAN_W-1:0]           span_d;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign draw_go = accept && !req_type;

	assign step_go = (state_q == ST_SEED_GO) || draw_go;
	assign step_x = (state_q == ST_IDLE) ? gen_q : x_q;

	assign div_go = (state_q == ST_DRAW_WAIT) && step_done && !rev_q;

	assign span_d = {range_high[31], range_high} - {range_low[31], range_low}
		+ spmr_pkg::SPAN_W'(1);

	// Seeding writes the table from the top slot down; a draw writes back
	// into the slot that it read.
	always_comb begin
		tbl_wr.en = 1'b0;
		tbl_wr.addr = slot_q;
		tbl_wr.data = step_val;
		if (state_q == ST_SEED_WAIT) begin
			tbl_wr.addr = cnt_q[spmr_pkg::IDX_W-1:0];
			tbl_wr.en = step_done && (cnt_q < spmr_pkg::CNT_W'(spmr_pkg::TABLE_DEPTH));
		end else if (state_q == ST_DRAW_WAIT) begin
			tbl_wr.en = step_done;
		end
	end

	spmr_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (step_go),
		.x      (step_x),
		.done   (step_done),
		.result (step_val)
	);

	spmr_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_en   (draw_go),
		.rd_addr (sel_q[spmr_pkg::IDX_W-1:0]),
		.rd_data (tbl_rd_data)
	);

	spmr_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  (tbl_rd_data),
		.divisor   (span_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEED_GO;
			x_q <= spmr_pkg::RESET_SEED;
			cnt_q <= spmr_pkg::CNT_W'(spmr_pkg::WARMUP_STEPS - 1);
			valid_q <= 1'b0;
			random_value_q <= '0;
			clamped_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_SEED_GO: begin
					state_q <= ST_SEED_WAIT;
				end
				ST_SEED_WAIT: begin
					if (step_done) begin
						x_q <= step_val;
						if (cnt_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							state_q <= ST_SEED_GO;
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req_type) begin
							x_q <= (seed == '0) ? spmr_pkg::RESET_SEED : seed;
							cnt_q <= spmr_pkg::CNT_W'(spmr_pkg::WARMUP_STEPS - 1);
							state_q <= ST_SEED_GO;
						end else begin
							state_q <= ST_DRAW_WAIT;
						end
					end
				end
				ST_DRAW_WAIT: begin
					if (step_done) begin
						if (rev_q) begin
							random_value_q <= lo_q;
							clamped_q <= 1'b1;
							valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						random_value_q <= lo_q + {1'b0, div_rem};
						clamped_q <= 1'b0;
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Generator state and draw operands. The seeding sequence leaves its last
	// value in both the generator and the selector.
	always_ff @(posedge clk) begin
		if ((state_q == ST_SEED_WAIT) && step_done && (cnt_q == '0)) begin
			gen_q <= step_val;
			sel_q <= step_val;
		end
		if ((state_q == ST_DRAW_WAIT) && step_done) begin
			gen_q <= step_val;
			sel_q <= tbl_rd_data;
		end
		if (draw_go) begin
			lo_q <= range_low;
			span_q <= span_d;
			rev_q <= (range_low > range_high);
			slot_q <= sel_q[spmr_pkg::IDX_W-1:0];
		end
	end

	assign valid = valid_q;
	assign random_value = random_value_q;
	assign clamped = clamped_q;

endmodule

`default_nettype wire

// ===== src/spmr_checker.sv =====
// ----------------------------------------------------------------------------
// spmr_checker: port-level checks of the random generator core
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spmr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        valid,
	input wire logic        clamped
);

	// An accepted word keeps the block busy and cannot give a result at once.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !valid))
		else $error("accepted word did not make the core busy");

	// A result word only appears once the core is ready for the next command.
	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !busy)
		else $error("result word shown while core busy");

	// Each draw gives one result word, never two in a row.
	a_valid_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("result word repeated");

	// The clamp flag is meaningful only with a result word, and a clamped result is not followed at once by another.
	a_clamp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && clamped) |=> !valid)
		else $error("clamped result followed by another result");

endmodule

bind shuffled_park_miller_rng_core spmr_checker u_spmr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.valid   (valid),
	.clamped (clamped)
);

`default_nettype wire
